// ----- rtl/core/lsu_pkg.sv -----
// Shared constants, state encoding and types for the load/store unit.
package lsu_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int AW        = $clog2(MEM_BYTES);

    localparam logic [3:0] BYTES_WIDE   = 4'd8;
    localparam logic [3:0] BYTES_NARROW = 4'd4;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_BASE,
        S_INDEX,
        S_ADDR,
        S_CHECK,
        S_LD,
        S_LDWB,
        S_ST,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        en;
        logic [4:0]  addr;
        logic [63:0] data;
    } t_rf_wr;

endpackage

// ----- rtl/core/lsu_in_if.sv -----
// Request channel: one load or store item.
interface lsu_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic               width_64;
    logic               unsigned_offset;
    logic               is_load;
    logic [11:0]        offset_field;
    logic [4:0]         base_reg;
    logic [4:0]         target_reg;
    logic signed [18:0] literal_offset;
    logic [63:0]        pc;

    modport source (
        output valid, command, width_64, unsigned_offset, is_load, offset_field,
               base_reg, target_reg, literal_offset, pc,
        input  ready
    );
    modport sink (
        input  valid, command, width_64, unsigned_offset, is_load, offset_field,
               base_reg, target_reg, literal_offset, pc,
        output ready
    );
endinterface

// ----- rtl/core/lsu_out_if.sv -----
// Result channel: one completed transfer.
interface lsu_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] address;
    logic [63:0] data;
    logic [63:0] base_after;
    logic        fault;

    modport source (
        output valid, address, data, base_after, fault,
        input  ready
    );
    modport sink (
        input  valid, address, data, base_after, fault,
        output ready
    );
endinterface

// ----- rtl/core/load_store_unit.sv -----
// Load/store unit top: sequencer over the register file and the byte memory.
// A faulting access skips memory; a load or store moves 4 or 8 bytes through the byte
//   memory port, one byte a cycle.
// One item at a time: ready returns only after the result is registered.
// Reset: register file cleared at once by valid bits; the byte memory is cleared by a
//   pass over all MEM_BYTES bytes after reset, during which no item is accepted.
module load_store_unit (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lsu_in_if.sink   i_item,
    lsu_out_if.source o_result
);

    lsu_pkg::t_state r_state, n_state;

    // latched item
    logic        r_cmd, r_wide, r_uoff, r_load;
    logic [11:0] r_field;
    logic [4:0]  r_xn, r_rt;
    logic [18:0] r_lit;
    logic [63:0] r_pc;

    // datapath
    logic [63:0] r_base, r_index, r_newbase, r_addr, r_data, r_bafter;
    logic        r_fault;
    logic [3:0]  r_cnt;
    logic [lsu_pkg::AW-1:0] r_clr;

    // output register
    logic        r_out_valid;
    logic [63:0] r_out_addr, r_out_data, r_out_base;
    logic        r_out_fault;

    logic [4:0]          rf_raddr;
    logic [63:0]         rf_rdata;
    lsu_pkg::t_rf_wr     rf_wr;

    logic                   mem_we;
    logic [lsu_pkg::AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]             mem_wdata, r_mem_rdata;
    logic [7:0]             mem [lsu_pkg::MEM_BYTES];

    logic        indexed, regoff, load_eff, out_load;
    logic [3:0]  size;
    logic [63:0] simm, add_a, add_b, sum, tval;
    logic [2:0]  lane;

    assign indexed  = !r_cmd && !r_uoff && !r_field[11];
    assign regoff   = !r_cmd && !r_uoff && r_field[11];
    assign load_eff = r_cmd || r_load;
    assign size     = r_wide ? lsu_pkg::BYTES_WIDE : lsu_pkg::BYTES_NARROW;
    assign simm     = {{55{r_field[10]}}, r_field[10:2]};
    assign lane     = 3'(r_cnt - 4'd1);

    lsu_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_raddr (rf_raddr),
        .i_wr    (rf_wr),
        .o_rdata (rf_rdata)
    );

    // effective address: one adder, operands chosen by mode
    always_comb begin
        if (r_cmd) begin
            add_a = r_pc;
            add_b = {{43{r_lit[18]}}, r_lit, 2'b00};
        end else if (r_uoff) begin
            add_a = r_base;
            add_b = r_wide ? {49'd0, r_field, 3'b000} : {50'd0, r_field, 2'b00};
        end else if (regoff) begin
            add_a = r_base;
            add_b = r_index;
        end else begin
            add_a = r_field[1] ? r_newbase : r_base;
            add_b = 64'd0;
        end
        sum = add_a + add_b;
    end

    // base write-back precedes the access, so a store of the base sends the new value
    always_comb begin
        tval = (indexed && (r_rt == r_xn)) ? r_newbase : rf_rdata;
        if (!r_wide) begin
            tval = {32'd0, tval[31:0]};
        end
    end

    assign out_load = (r_state == lsu_pkg::S_DONE) && (!r_out_valid || o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsu_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        rf_raddr  = r_rt;
        rf_wr     = '0;
        mem_we    = 1'b0;
        mem_waddr = r_clr;
        mem_wdata = 8'd0;
        mem_raddr = r_addr[lsu_pkg::AW-1:0] + lsu_pkg::AW'(r_cnt[2:0]);
        case (r_state)
            lsu_pkg::S_CLEAR: begin
                mem_we = 1'b1;
                if (r_clr == lsu_pkg::AW'(lsu_pkg::MEM_BYTES - 1)) begin
                    n_state = lsu_pkg::S_IDLE;
                end
            end
            lsu_pkg::S_IDLE: begin
                rf_raddr = i_item.base_reg;
                if (i_item.valid) begin
                    n_state = lsu_pkg::S_BASE;
                end
            end
            lsu_pkg::S_BASE: begin
                rf_raddr = r_field[10:6];
                n_state  = lsu_pkg::S_INDEX;
            end
            lsu_pkg::S_INDEX: begin
                rf_raddr = r_rt;
                n_state  = lsu_pkg::S_ADDR;
            end
            lsu_pkg::S_ADDR: begin
                rf_wr.en   = indexed;
                rf_wr.addr = r_xn;
                rf_wr.data = r_newbase;
                n_state    = lsu_pkg::S_CHECK;
            end
            lsu_pkg::S_CHECK: begin
                if (r_addr > (64'(lsu_pkg::MEM_BYTES) - 64'(size))) begin
                    n_state = lsu_pkg::S_DONE;
                end else if (load_eff) begin
                    n_state = lsu_pkg::S_LD;
                end else begin
                    n_state = lsu_pkg::S_ST;
                end
            end
            lsu_pkg::S_LD: begin
                if (r_cnt == size) begin
                    n_state = lsu_pkg::S_LDWB;
                end
            end
            lsu_pkg::S_LDWB: begin
                rf_wr.en   = 1'b1;
                rf_wr.addr = r_rt;
                rf_wr.data = r_data;
                n_state    = lsu_pkg::S_DONE;
            end
            lsu_pkg::S_ST: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr[lsu_pkg::AW-1:0] + lsu_pkg::AW'(r_cnt[2:0]);
                mem_wdata = r_data[8*r_cnt[2:0] +: 8];
                if (r_cnt == size - 4'd1) begin
                    n_state = lsu_pkg::S_DONE;
                end
            end
            lsu_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = lsu_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lsu_pkg::S_IDLE;
            end
        endcase
    end

    assign i_item.ready = (r_state == lsu_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_mem_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (r_state == lsu_pkg::S_CLEAR) begin
            r_clr <= r_clr + lsu_pkg::AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            lsu_pkg::S_IDLE: begin
                if (i_item.valid) begin
                    r_cmd   <= i_item.command;
                    r_wide  <= i_item.width_64;
                    r_uoff  <= i_item.unsigned_offset;
                    r_load  <= i_item.is_load;
                    r_field <= i_item.offset_field;
                    r_xn    <= i_item.base_reg;
                    r_rt    <= i_item.target_reg;
                    r_lit   <= i_item.literal_offset;
                    r_pc    <= i_item.pc;
                end
            end
            lsu_pkg::S_BASE: begin
                r_base <= rf_rdata;
            end
            lsu_pkg::S_INDEX: begin
                r_index   <= rf_rdata;
                r_newbase <= r_base + simm;
            end
            lsu_pkg::S_ADDR: begin
                r_addr   <= sum;
                r_data   <= tval;
                r_bafter <= r_cmd ? 64'd0 : (indexed ? r_newbase : r_base);
            end
            lsu_pkg::S_CHECK: begin
                r_cnt   <= 4'd0;
                r_fault <= 1'b0;
                if (r_addr > (64'(lsu_pkg::MEM_BYTES) - 64'(size))) begin
                    r_fault <= 1'b1;
                    r_data  <= 64'd0;
                end else if (load_eff) begin
                    r_data <= 64'd0;
                end
            end
            lsu_pkg::S_LD: begin
                // read data is registered, so each byte lands in the cycle after its address
                if (r_cnt != 4'd0) begin
                    r_data[8*lane +: 8] <= r_mem_rdata;
                end
                r_cnt <= r_cnt + 4'd1;
            end
            lsu_pkg::S_LDWB: begin
                if (!r_cmd && (r_rt == r_xn)) begin
                    r_bafter <= r_data;
                end
            end
            lsu_pkg::S_ST: begin
                r_cnt <= r_cnt + 4'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_addr  <= r_addr;
            r_out_data  <= r_data;
            r_out_base  <= r_bafter;
            r_out_fault <= r_fault;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.address    = r_out_addr;
    assign o_result.data       = r_out_data;
    assign o_result.base_after = r_out_base;
    assign o_result.fault      = r_out_fault;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid && i_item.ready |=> r_state == lsu_pkg::S_BASE)
        else $error("accepted item did not start the base read");

    a_mem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (32'(mem_waddr) < 32'(lsu_pkg::MEM_BYTES)))
        else $error("byte memory write outside memory");

    a_rf_write_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_wr.en |-> (r_state == lsu_pkg::S_ADDR) || (r_state == lsu_pkg::S_LDWB))
        else $error("register file written outside write-back slots");

    a_out_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.ready && !out_load |=> !o_result.valid)
        else $error("result shown twice");

    a_fault_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lsu_pkg::S_DONE) && r_fault |-> $past(r_state) == lsu_pkg::S_CHECK
        || $past(r_state) == lsu_pkg::S_DONE)
        else $error("faulting access touched memory");

endmodule

// ----- rtl/core/lsu_regfile.sv -----
// 32 x 64 register file, one registered read port, one write port, valid bits for reset.
module lsu_regfile (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [4:0]           i_raddr,
    input  lsu_pkg::t_rf_wr      i_wr,
    output logic [63:0]          o_rdata
);

    logic [63:0] mem [32];
    logic [31:0] r_valid;
    logic [63:0] r_rdata;
    logic        r_rvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata  <= mem[i_raddr];
        r_rvalid <= r_valid[i_raddr];
    end

    // never-written entries read as zero
    assign o_rdata = r_rvalid ? r_rdata : 64'd0;

endmodule

// ----- bench/tb.sv -----
// Testbench for load_store_unit: directed and random transfers checked against a local model.
`timescale 1ns / 1ps

module tb;
    import lsu_pkg::*;

    localparam logic CMD_XFER    = 1'b0;
    localparam logic CMD_LITERAL = 1'b1;
    localparam int   MODE_REG    = 11;   // offset_field bit: register offset vs. indexed
    localparam int   MODE_PRE    = 1;    // offset_field bit: pre-index vs. post-index
    localparam longint unsigned LAST_WIDE = MEM_BYTES - 8;
    localparam int   CYCLE_LIMIT = MEM_BYTES + 250_000;

    typedef struct packed {
        logic        command;
        logic        width_64;
        logic        unsigned_offset;
        logic        is_load;
        logic [11:0] offset_field;
        logic [4:0]  base_reg;
        logic [4:0]  target_reg;
        logic [18:0] literal_offset;
        logic [63:0] pc;
    } t_xfer_op;

    typedef struct packed {
        logic [63:0] address;
        logic [63:0] data;
        logic [63:0] base_after;
        logic        fault;
    } t_xfer_res;

    logic clk;
    logic rst_n;
    logic idle_en;
    int   n_errors;
    int   n_checked;
    int   n_literal;
    int   n_store;
    int   n_wb;
    int   n_fault;
    int   cycle_count;

    logic [63:0] reg_image [32];
    logic [7:0]  mem_image [0:MEM_BYTES-1];
    t_xfer_res   results_due [$];
    t_xfer_res   due_head;

    lsu_in_if  in_ch ();
    lsu_out_if out_ch ();

    load_store_unit u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (in_ch),
        .o_result (out_ch)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t timeout: %0d results still due", $time, results_due.size());
            $display("tb: errors");
            $finish;
        end
    end

    always @(posedge clk) begin
        out_ch.ready <= !idle_en || ($urandom_range(99) >= 30);
    end

    // ---------------------------------------------------------------- model

    function automatic logic [63:0] sext_literal(input logic [18:0] lit);
        return {{45{lit[18]}}, lit} << 2;
    endfunction

    function automatic t_xfer_res execute_xfer(input t_xfer_op op);
        logic [63:0] addr;
        logic [63:0] old_base;
        logic [63:0] simm;
        logic [63:0] v;
        logic [3:0]  nbytes;
        logic        literal;
        logic        fault;
        t_xfer_res   r;
        nbytes  = op.width_64 ? BYTES_WIDE : BYTES_NARROW;
        literal = (op.command == CMD_LITERAL);
        if (literal) begin
            addr = op.pc + sext_literal(op.literal_offset);
            n_literal++;
        end else if (op.unsigned_offset) begin
            addr = reg_image[op.base_reg] + op.offset_field * nbytes;
        end else if (op.offset_field[MODE_REG]) begin
            addr = reg_image[op.base_reg] + reg_image[op.offset_field[10:6]];
        end else begin
            simm     = {{55{op.offset_field[10]}}, op.offset_field[10:2]};
            old_base = reg_image[op.base_reg];
            reg_image[op.base_reg] = old_base + simm;
            addr = op.offset_field[MODE_PRE] ? old_base + simm : old_base;
            n_wb++;
        end
        if (!literal && !op.is_load)
            n_store++;
        fault = addr > 64'(MEM_BYTES) - 64'(nbytes);
        v = '0;
        if (fault) begin
            n_fault++;
        end else if (literal || op.is_load) begin
            for (int i = 0; i < nbytes; i++)
                v[8*i +: 8] = mem_image[int'(addr) + i];
            reg_image[op.target_reg] = v;
        end else begin
            v = reg_image[op.target_reg];
            if (!op.width_64)
                v[63:32] = '0;
            for (int i = 0; i < nbytes; i++)
                mem_image[int'(addr) + i] = v[8*i +: 8];
        end
        r.address    = addr;
        r.data       = v;
        r.base_after = literal ? 64'd0 : reg_image[op.base_reg];
        r.fault      = fault;
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge clk) begin
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
            if (results_due.size() == 0) begin
                $display("%0t unexpected result: expected none actual addr %h data %h",
                         $time, out_ch.address, out_ch.data);
                n_errors++;
            end else begin
                due_head = results_due.pop_front();
                check_field("address", due_head.address, out_ch.address);
                check_field("data", due_head.data, out_ch.data);
                check_field("base_after", due_head.base_after, out_ch.base_after);
                check_field("fault", 64'(due_head.fault), 64'(out_ch.fault));
                n_checked++;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic send_xfer(input t_xfer_op op);
        if (idle_en && $urandom_range(99) < 30) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.command         <= op.command;
        in_ch.width_64        <= op.width_64;
        in_ch.unsigned_offset <= op.unsigned_offset;
        in_ch.is_load         <= op.is_load;
        in_ch.offset_field    <= op.offset_field;
        in_ch.base_reg        <= op.base_reg;
        in_ch.target_reg      <= op.target_reg;
        in_ch.literal_offset  <= op.literal_offset;
        in_ch.pc              <= op.pc;
        do @(posedge clk); while (!in_ch.ready);
        results_due.push_back(execute_xfer(op));
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
    endtask

    function automatic t_xfer_op mk(input logic cmd, input logic wide, input logic uoff,
                                    input logic ld, input logic [11:0] field,
                                    input logic [4:0] xn, input logic [4:0] rt,
                                    input logic [18:0] lit, input logic [63:0] pc);
        t_xfer_op op;
        op.command         = cmd;
        op.width_64        = wide;
        op.unsigned_offset = uoff;
        op.is_load         = ld;
        op.offset_field    = field;
        op.base_reg        = xn;
        op.target_reg      = rt;
        op.literal_offset  = lit;
        op.pc              = pc;
        return op;
    endfunction

    function automatic logic [11:0] indexed(input int simm, input logic pre);
        return {1'b0, 9'(simm), pre, 1'b0};
    endfunction

    function automatic logic [11:0] reg_offset(input logic [4:0] xm);
        return {1'b1, xm, 6'b0};
    endfunction

    // Prefer a register that currently holds a usable address.
    function automatic logic [4:0] pick_pointer();
        logic [4:0] r;
        for (int t = 0; t < 8; t++) begin
            r = 5'($urandom);
            if (reg_image[r] <= LAST_WIDE)
                return r;
        end
        return r;
    endfunction

    function automatic t_xfer_op random_xfer();
        t_xfer_op        op;
        int              kind;
        int              lo;
        int              hi;
        longint unsigned b;
        longint unsigned lim;
        logic [63:0]     tgt;
        logic [4:0]      xm;
        kind = $urandom_range(99);
        op = mk(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 12'($urandom),
                5'($urandom), 5'($urandom), 19'($urandom), {$urandom, $urandom});
        if (kind < 8)
            return op;    // noise: every field free
        op.base_reg = pick_pointer();
        b = reg_image[op.base_reg];
        if (kind < 22) begin
            op.command = CMD_LITERAL;
            if ($urandom_range(4) == 0)
                tgt = $urandom_range(MEM_BYTES - 12, MEM_BYTES - 1);
            else
                tgt = $urandom_range(0, MEM_BYTES - 8);
            op.pc = tgt - sext_literal(op.literal_offset);
            return op;
        end
        op.command = CMD_XFER;
        if (kind < 47) begin
            op.unsigned_offset = 1'b1;
            lim = (b > LAST_WIDE) ? 4095 : (LAST_WIDE - b) / (op.width_64 ? 8 : 4);
            if (lim > 4095)
                lim = 4095;
            op.offset_field = 12'($urandom_range(0, int'(lim)));
        end else if (kind < 65) begin
            op.unsigned_offset = 1'b0;
            xm = 5'($urandom);
            for (int t = 0; t < 8 && b + reg_image[xm] > LAST_WIDE; t++)
                xm = 5'($urandom);
            op.offset_field = {1'b1, xm, 6'($urandom)};
        end else begin
            op.unsigned_offset = 1'b0;
            if (b <= LAST_WIDE) begin
                // keep the written-back base inside memory
                lo = (b >= 256) ? -256 : -int'(b);
                hi = (LAST_WIDE - b >= 255) ? 255 : int'(LAST_WIDE - b);
                op.offset_field = {1'b0, 9'($urandom_range(0, hi - lo) + lo),
                                   1'($urandom), 1'($urandom)};
            end else begin
                op.offset_field[MODE_REG] = 1'b0;
            end
        end
        return op;
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_cleared_state();
        send_xfer(mk(CMD_XFER, 1, 1, 1, 12'd0, 5'd0, 5'd1, '0, '0));
        send_xfer(mk(CMD_LITERAL, 1, 0, 0, '0, '0, 5'd1, '0, 64'(LAST_WIDE)));
    endtask

    task automatic test_index_writeback();
        send_xfer(mk(CMD_XFER, 1, 0, 0, indexed(255, 0), 5'd2, 5'd2, '0, '0));
        send_xfer(mk(CMD_XFER, 1, 0, 1, indexed(-256, 1), 5'd3, 5'd9, '0, '0));
        send_xfer(mk(CMD_XFER, 0, 0, 0, indexed(16, 1), 5'd4, 5'd4, '0, '0));
        send_xfer(mk(CMD_XFER, 1, 0, 1, indexed(-1, 0), 5'd5, 5'd6, '0, '0));
        send_xfer(mk(CMD_XFER, 1, 0, 1, indexed(8, 0), 5'd2, 5'd2, '0, '0));
    endtask

    task automatic test_register_offset();
        send_xfer(mk(CMD_XFER, 1, 0, 0, indexed(100, 1), 5'd31, 5'd31, '0, '0));
        send_xfer(mk(CMD_XFER, 0, 0, 0, reg_offset(5'd4), 5'd31, 5'd3, '0, '0));
        send_xfer(mk(CMD_XFER, 0, 0, 1, reg_offset(5'd31), 5'd4, 5'd7, '0, '0));
        send_xfer(mk(CMD_XFER, 1, 0, 1, reg_offset(5'd31), 5'd4, 5'd31, '0, '0));
    endtask

    task automatic test_unsigned_offset();
        send_xfer(mk(CMD_XFER, 1, 1, 0, 12'hFFF, 5'd0, 5'd3, '0, '0));
        send_xfer(mk(CMD_XFER, 0, 1, 1, 12'hFFF, 5'd0, 5'd8, '0, '0));
        send_xfer(mk(CMD_XFER, 1, 1, 1, 12'hFFF, 5'd4, 5'd10, '0, '0));
        send_xfer(mk(CMD_XFER, 1, 1, 1, 12'd1, 5'd3, 5'd11, '0, '0));
    endtask

    task automatic test_load_literal();
        send_xfer(mk(CMD_LITERAL, 1, 1, 0, 12'hFFF, 5'd31, 5'd12, '0, 64'(MEM_BYTES - 4)));
        send_xfer(mk(CMD_LITERAL, 0, 0, 1, '0, '0, 5'd12, '0, 64'(MEM_BYTES - 4)));
        send_xfer(mk(CMD_LITERAL, 0, 0, 1, '0, '0, 5'd13, '0, 64'(MEM_BYTES - 3)));
        send_xfer(mk(CMD_LITERAL, 1, 0, 1, '0, '0, 5'd14, 19'h3FFFF, 64'd0));
        send_xfer(mk(CMD_LITERAL, 1, 0, 1, '0, '0, 5'd15, 19'h40000, 64'd1048576 + 32760));
        send_xfer(mk(CMD_LITERAL, 0, 0, 1, '0, '0, 5'd16, 19'd1, '1));
    endtask

    task automatic test_random_mix(input int count, input logic with_idle);
        idle_en = with_idle;
        for (int n = 0; n < count; n++)
            send_xfer(random_xfer());
    endtask

    initial begin
        in_ch.valid           <= 1'b0;
        in_ch.command         <= CMD_XFER;
        in_ch.width_64        <= 1'b0;
        in_ch.unsigned_offset <= 1'b0;
        in_ch.is_load         <= 1'b0;
        in_ch.offset_field    <= '0;
        in_ch.base_reg        <= '0;
        in_ch.target_reg      <= '0;
        in_ch.literal_offset  <= '0;
        in_ch.pc              <= '0;
        rst_n                 <= 1'b0;
        idle_en     = 1'b1;
        n_errors    = 0;
        n_checked   = 0;
        n_literal   = 0;
        n_store     = 0;
        n_wb        = 0;
        n_fault     = 0;
        cycle_count = 0;
        foreach (reg_image[i])
            reg_image[i] = '0;
        foreach (mem_image[i])
            mem_image[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_cleared_state();
        test_index_writeback();
        test_register_offset();
        test_unsigned_offset();
        test_load_literal();
        test_random_mix(160, 1'b0);
        drain_results();
        test_random_mix(370, 1'b1);
        drain_results();
        repeat (32) @(posedge clk);

        if (results_due.size() != 0) begin
            $display("%0t %0d results never arrived", $time, results_due.size());
            n_errors++;
        end
        $display("tb: %0d transfers checked (%0d load literal, %0d stores, %0d write-backs)",
                 n_checked, n_literal, n_store, n_wb);
        $display("tb: %0d out-of-range accesses, random part with and without idling",
                 n_fault);
        if (n_errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/lsu_pkg.sv
rtl/core/lsu_in_if.sv
rtl/core/lsu_out_if.sv
rtl/core/lsu_regfile.sv
rtl/core/load_store_unit.sv
bench/tb.sv
